/* sv/discrete_command_line_controller_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the discrete command line controller checker.
// Both macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DISCRETE_COMMAND_LINE_CONTROLLER_CORE_ASSERT_SVH
`define DISCRETE_COMMAND_LINE_CONTROLLER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DCLC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DCLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/dclc_pkg.sv */
// ----------------------------------------------------------------------------
// dclc_pkg
// Request/result types, codes and helpers shared by the command line
// controller, its checker and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package dclc_pkg;

    // Request modes
    localparam logic [1:0] MODE_EXEC      = 2'd0;
    localparam logic [1:0] MODE_LOAD_CMD  = 2'd1;
    localparam logic [1:0] MODE_LOAD_PORT = 2'd2;

    // Command kinds
    localparam logic [1:0] KIND_STRB  = 2'd0;
    localparam logic [1:0] KIND_STEP  = 2'd1;
    localparam logic [1:0] KIND_SET   = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // System controller strobe
    localparam logic [15:0] SYSCTL_ADDR = 16'h030E;
    localparam logic [15:0] SYSCTL_CLR  = 16'd2;
    localparam logic [15:0] SYSCTL_SET  = 16'd3;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_STROBE_VIA_SYSCTL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STROBE_LINE_CMD   = 1'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  entry_index;
        logic [15:0] set_value;
        logic        group_end;
        logic [1:0]  load_kind;
        logic [4:0]  load_port_index;
        logic [15:0] load_mask;
        logic [15:0] load_bus_address;
    } cmd_req_t;

    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_address;
        logic [15:0] write_data;
        logic        reply_status;
        logic        strobe_order_error;
        logic        last_result;
    } rsp_t;

    // Remainder of an 8-bit index by a table size (1..256), restoring style:
    // eight compare/subtract steps on 9-bit values.
    function automatic logic [7:0] wrap_index(input logic [7:0] value,
                                              input logic [8:0] entries);
        logic [8:0] rem;
        rem = '0;
        for (int i = 7; i >= 0; i--)
        begin
            rem = {rem[7:0], value[i]};
            if (rem >= entries)
            begin
                rem = rem - entries;
            end
        end
        return rem[7:0];
    endfunction

endpackage

`default_nettype wire

/* sv/dclc_ram.sv */
// ----------------------------------------------------------------------------
// dclc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dclc_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* sv/discrete_command_line_controller_core.sv */
// ----------------------------------------------------------------------------
// discrete_command_line_controller_core
// Command/port table controller that turns command requests into bus writes
// of port shadow words, with group-end strobe handling.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_valid/cmd_stall/cmd_req carry requests: load a command entry, load a
//   port entry, or execute a command. rsp_valid/rsp_stall/rsp carry results;
//   an execute produces one to three results, the final one with last_result.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the two strobe registers;
//   cfg_ready is always high. Writes are to be made only while the block is idle (not enforced).
// Timing:
//   Load requests do not raise cmd_stall. An execute holds cmd_stall high
//   until its last result has been placed in the output register.
//   Each line write costs a command-table read (none for the clear write
//   of a STEP) and a port-table read, both RAMs with a separate write port
//   and a registered read port, then one read-modify-write.
// Reset:
//   Strobe state and control registers clear; table contents are left as they are
//   and must be loaded before use. Port shadows read as zero until written.
// Back-pressure:
//   A result waits in the output register while rsp_stall is high; the
//   sequencer holds until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module discrete_command_line_controller_core
    import dclc_pkg::*;
#(
    parameter int unsigned COMMAND_ENTRIES = 256,
    parameter int unsigned PORT_ENTRIES    = 32,
    parameter int unsigned DATA_BITS       = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    output logic                        cmd_stall,
    input  wire cmd_req_t               cmd_req,
    output logic                        rsp_valid,
    input  wire logic                   rsp_stall,
    output rsp_t                        rsp,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data
);

    localparam int unsigned CMD_IDX_W  = $clog2(COMMAND_ENTRIES);
    localparam int unsigned PORT_IDX_W = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
    localparam int unsigned CMD_W      = 2 + PORT_IDX_W + 16;
    localparam int unsigned PORT_W     = 16 + DATA_BITS;
    localparam logic [8:0]  CMD_DIV    = 9'(COMMAND_ENTRIES);
    localparam logic [8:0]  PORT_DIV   = 9'(PORT_ENTRIES);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DECODE  = 7'b0000010,
        S_LINE    = 7'b0000100,
        S_PORT_RD = 7'b0001000,
        S_APPLY   = 7'b0010000,
        S_EMIT    = 7'b0100000,
        S_GROUP   = 7'b1000000
    } state_t;

    // Control state
    state_t                  state_reg, state_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    active_reg, active_next;
    logic [CMD_IDX_W-1:0]    owner_reg, owner_next;
    logic                    in_group_reg, in_group_next;
    logic                    via_sysctl_reg, via_sysctl_next;
    logic [CMD_IDX_W-1:0]    sc_reg, sc_next;
    logic [PORT_ENTRIES-1:0] shadow_valid_reg, shadow_valid_next;

    // Item and operation payload
    logic [CMD_IDX_W-1:0]  item_cmd_reg, item_cmd_next;
    logic [15:0]           item_val_reg, item_val_next;
    logic                  item_gend_reg, item_gend_next;
    logic                  status_reg, status_next;
    logic                  op_set_reg, op_set_next;
    logic                  op_or_reg, op_or_next;
    logic                  op_err_reg, op_err_next;
    logic [PORT_IDX_W-1:0] op_port_reg, op_port_next;
    logic [DATA_BITS-1:0]  op_mask_reg, op_mask_next;
    logic                  pend_clear_reg, pend_clear_next;
    logic                  group_phase_reg, group_phase_next;
    logic                  fix_wvalid_reg, fix_wvalid_next;
    logic [15:0]           fix_data_reg, fix_data_next;
    logic                  shadow_ok_reg;
    rsp_t                  out_reg, out_next;

    // Table RAM ports
    logic                  cmd_wr_en;
    logic [CMD_IDX_W-1:0]  cmd_wr_addr;
    logic [CMD_W-1:0]      cmd_wr_data;
    logic [CMD_IDX_W-1:0]  cmd_rd_addr;
    logic [CMD_W-1:0]      cmd_rd_data;
    logic                  port_wr_en;
    logic [PORT_IDX_W-1:0] port_wr_addr;
    logic [PORT_W-1:0]     port_wr_data;
    logic [PORT_IDX_W-1:0] port_rd_addr;
    logic [PORT_W-1:0]     port_rd_data;

    // Decoded fields
    logic                  cmd_accept;
    logic                  out_free;
    logic                  last_now;
    logic                  step_done;
    logic [CMD_IDX_W-1:0]  in_cmd_idx;
    logic [PORT_IDX_W-1:0] in_port_idx;
    logic [PORT_IDX_W-1:0] in_load_port;
    logic [1:0]            rd_kind;
    logic [PORT_IDX_W-1:0] rd_port;
    logic [DATA_BITS-1:0]  rd_mask;
    logic [15:0]           rd_bus_addr;
    logic [DATA_BITS-1:0]  rd_shadow;
    logic [DATA_BITS-1:0]  new_shadow;

    assign cfg_ready = 1'b1;
    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign cmd_accept = cmd_valid && (state_reg == S_IDLE);
    assign out_free   = !out_valid_reg || !rsp_stall;

    // Index wrapping on request fields
    assign in_cmd_idx   = CMD_IDX_W'(wrap_index(cmd_req.entry_index, CMD_DIV));
    assign in_port_idx  = PORT_IDX_W'(wrap_index(cmd_req.entry_index, PORT_DIV));
    assign in_load_port = PORT_IDX_W'(wrap_index(8'(cmd_req.load_port_index), PORT_DIV));

    // Table read fields
    assign rd_kind     = cmd_rd_data[CMD_W-1 -: 2];
    assign rd_port     = cmd_rd_data[16 +: PORT_IDX_W];
    assign rd_mask     = DATA_BITS'(cmd_rd_data[15:0]);
    assign rd_bus_addr = port_rd_data[DATA_BITS +: 16];
    assign rd_shadow   = shadow_ok_reg ? port_rd_data[DATA_BITS-1:0] : '0;

    // Shared line update: OR in value, set mask bits or clear mask bits
    always_comb
    begin
        if (op_or_reg)
        begin
            new_shadow = rd_shadow | DATA_BITS'(item_val_reg);
        end
        else if (op_set_reg)
        begin
            new_shadow = rd_shadow | op_mask_reg;
        end
        else
        begin
            new_shadow = rd_shadow & ~op_mask_reg;
        end
    end

    // A result is last unless a clear step or a group strobe follows
    assign last_now = group_phase_reg ||
                      !(pend_clear_reg || (item_gend_reg && in_group_reg));

    dclc_ram #(
        .WIDTH (CMD_W),
        .DEPTH (COMMAND_ENTRIES)
    ) u_cmd_ram (
        .clk     (clk),
        .wr_en   (cmd_wr_en),
        .wr_addr (cmd_wr_addr),
        .wr_data (cmd_wr_data),
        .rd_addr (cmd_rd_addr),
        .rd_data (cmd_rd_data)
    );

    dclc_ram #(
        .WIDTH (PORT_W),
        .DEPTH (PORT_ENTRIES)
    ) u_port_ram (
        .clk     (clk),
        .wr_en   (port_wr_en),
        .wr_addr (port_wr_addr),
        .wr_data (port_wr_data),
        .rd_addr (port_rd_addr),
        .rd_data (port_rd_data)
    );

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        out_valid_next    = out_valid_reg;
        active_next       = active_reg;
        owner_next        = owner_reg;
        in_group_next     = in_group_reg;
        shadow_valid_next = shadow_valid_reg;
        item_cmd_next     = item_cmd_reg;
        item_val_next     = item_val_reg;
        item_gend_next    = item_gend_reg;
        status_next       = status_reg;
        op_set_next       = op_set_reg;
        op_or_next        = op_or_reg;
        op_err_next       = op_err_reg;
        op_port_next      = op_port_reg;
        op_mask_next      = op_mask_reg;
        pend_clear_next   = pend_clear_reg;
        group_phase_next  = group_phase_reg;
        fix_wvalid_next   = fix_wvalid_reg;
        fix_data_next     = fix_data_reg;
        out_next          = out_reg;
        step_done         = 1'b0;

        cmd_wr_en    = 1'b0;
        cmd_wr_addr  = in_cmd_idx;
        cmd_wr_data  = {cmd_req.load_kind, in_load_port, cmd_req.load_mask};
        cmd_rd_addr  = sc_reg;
        port_wr_en   = 1'b0;
        port_wr_addr = op_port_reg;
        port_wr_data = {rd_bus_addr, new_shadow};
        port_rd_addr = op_port_reg;

        // Output register drains
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_rd_addr = in_cmd_idx;
                if (cmd_accept)
                begin
                    unique case (cmd_req.mode)
                        MODE_LOAD_CMD:
                        begin
                            cmd_wr_en = 1'b1;
                        end
                        MODE_LOAD_PORT:
                        begin
                            port_wr_en   = 1'b1;
                            port_wr_addr = in_port_idx;
                            port_wr_data = {cmd_req.load_bus_address, {DATA_BITS{1'b0}}};
                            shadow_valid_next[in_port_idx] = 1'b1;
                        end
                        MODE_EXEC:
                        begin
                            item_cmd_next    = in_cmd_idx;
                            item_val_next    = cmd_req.set_value;
                            item_gend_next   = cmd_req.group_end;
                            status_next      = 1'b0;
                            op_or_next       = 1'b0;
                            op_err_next      = 1'b0;
                            pend_clear_next  = 1'b0;
                            group_phase_next = 1'b0;
                            state_next       = S_DECODE;
                        end
                        default:
                        begin
                            // unused mode: request dropped
                        end
                    endcase
                end
            end

            S_DECODE:
            begin
                // Item's command entry is on the read port
                port_rd_addr = rd_port;
                op_port_next = rd_port;
                op_mask_next = rd_mask;
                unique case (rd_kind)
                    KIND_STRB:
                    begin
                        in_group_next = 1'b1;
                        if (active_reg)
                        begin
                            // clear the line of the last strobing command
                            cmd_rd_addr = owner_reg;
                            op_set_next = 1'b0;
                            state_next  = S_LINE;
                        end
                        else
                        begin
                            op_set_next = 1'b1;
                            state_next  = S_APPLY;
                        end
                    end
                    KIND_STEP:
                    begin
                        op_set_next     = 1'b1;
                        pend_clear_next = 1'b1;
                        state_next      = S_APPLY;
                    end
                    KIND_SET:
                    begin
                        op_set_next = (item_val_reg != 16'd0);
                        op_or_next  = (rd_mask == '0);
                        state_next  = S_APPLY;
                    end
                    KIND_SPARE:
                    begin
                        status_next     = 1'b1;
                        fix_wvalid_next = 1'b0;
                        fix_data_next   = 16'd0;
                        state_next      = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_LINE:
            begin
                // Target command entry is on the read port
                port_rd_addr = rd_port;
                op_port_next = rd_port;
                op_mask_next = rd_mask;
                state_next   = S_APPLY;
            end

            S_PORT_RD:
            begin
                state_next = S_APPLY;
            end

            S_APPLY:
            begin
                if (out_free)
                begin
                    port_wr_en                      = 1'b1;
                    shadow_valid_next[op_port_reg]  = 1'b1;
                    out_valid_next                  = 1'b1;
                    out_next.write_valid            = 1'b1;
                    out_next.write_address          = rd_bus_addr;
                    out_next.write_data             = 16'(new_shadow);
                    out_next.reply_status           = status_reg;
                    out_next.strobe_order_error     = op_err_reg;
                    out_next.last_result            = last_now;
                    if (pend_clear_reg)
                    begin
                        pend_clear_next = 1'b0;
                        op_set_next     = 1'b0;
                        state_next      = S_PORT_RD;
                    end
                    else
                    begin
                        step_done = 1'b1;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next                  = 1'b1;
                    out_next.write_valid            = fix_wvalid_reg;
                    out_next.write_address          = fix_wvalid_reg ? SYSCTL_ADDR : 16'd0;
                    out_next.write_data             = fix_data_reg;
                    out_next.reply_status           = status_reg;
                    out_next.strobe_order_error     = op_err_reg;
                    out_next.last_result            = last_now;
                    step_done                       = 1'b1;
                end
            end

            S_GROUP:
            begin
                in_group_next    = 1'b0;
                group_phase_next = 1'b1;
                op_or_next       = 1'b0;
                fix_wvalid_next  = 1'b1;
                if (active_reg)
                begin
                    active_next   = 1'b0;
                    op_err_next   = (item_cmd_reg != owner_reg);
                    op_set_next   = 1'b0;
                    fix_data_next = SYSCTL_CLR;
                end
                else
                begin
                    active_next   = 1'b1;
                    owner_next    = item_cmd_reg;
                    op_err_next   = 1'b0;
                    op_set_next   = 1'b1;
                    fix_data_next = SYSCTL_SET;
                end
                state_next = via_sysctl_reg ? S_EMIT : S_LINE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // End of the main part of an item
        if (step_done)
        begin
            if (!group_phase_reg && item_gend_reg && in_group_reg)
            begin
                state_next = S_GROUP;
            end
            else
            begin
                state_next = S_IDLE;
                if (item_gend_reg)
                begin
                    in_group_next = 1'b0;
                end
            end
        end
    end

    // Configuration registers
    always_comb
    begin
        via_sysctl_next = via_sysctl_reg;
        sc_next         = sc_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_STROBE_VIA_SYSCTL: via_sysctl_next = cfg_data[0];
                REG_STROBE_LINE_CMD:   sc_next = CMD_IDX_W'(wrap_index(cfg_data, CMD_DIV));
                default:               via_sysctl_next = via_sysctl_reg;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            active_reg       <= 1'b0;
            owner_reg        <= '0;
            in_group_reg     <= 1'b0;
            via_sysctl_reg   <= 1'b0;
            sc_reg           <= '0;
            shadow_valid_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            active_reg       <= active_next;
            owner_reg        <= owner_next;
            in_group_reg     <= in_group_next;
            via_sysctl_reg   <= via_sysctl_next;
            sc_reg           <= sc_next;
            shadow_valid_reg <= shadow_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_cmd_reg    <= item_cmd_next;
        item_val_reg    <= item_val_next;
        item_gend_reg   <= item_gend_next;
        status_reg      <= status_next;
        op_set_reg      <= op_set_next;
        op_or_reg       <= op_or_next;
        op_err_reg      <= op_err_next;
        op_port_reg     <= op_port_next;
        op_mask_reg     <= op_mask_next;
        pend_clear_reg  <= pend_clear_next;
        group_phase_reg <= group_phase_next;
        fix_wvalid_reg  <= fix_wvalid_next;
        fix_data_reg    <= fix_data_next;
        out_reg         <= out_next;
        shadow_ok_reg   <= shadow_valid_reg[port_rd_addr];
    end

endmodule

`default_nettype wire

/* sv/dclc_checker.sv */
// ----------------------------------------------------------------------------
// dclc_checker
// Port-level checks for the command line controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "discrete_command_line_controller_core_assert.svh"

module dclc_checker
    import dclc_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     cmd_valid,
    input wire logic     cmd_stall,
    input wire cmd_req_t cmd_req,
    input wire logic     rsp_valid,
    input wire logic     rsp_stall,
    input wire rsp_t     rsp
);

    // Stalled result holds
    `DCLC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result changed while stalled")

    // An accepted execute request stalls the request channel in the next cycle
    `DCLC_ASSERT_NEXT(a_exec_busy, cmd_valid && !cmd_stall && (cmd_req.mode == MODE_EXEC), cmd_stall, "execute did not stall the request channel")

    // A result without a bus write carries zero address and data
    `DCLC_ASSERT_SAME(a_no_write_zero, rsp_valid && !rsp.write_valid, (rsp.write_address == 16'd0) && (rsp.write_data == 16'd0), "idle result carries write data")

    // A strobe order error only rides on the final, written result
    `DCLC_ASSERT_SAME(a_err_last, rsp_valid && rsp.strobe_order_error, rsp.write_valid && rsp.last_result, "strobe order error on a non-final result")

endmodule

bind discrete_command_line_controller_core dclc_checker u_dclc_checker (.*);

`default_nettype wire

/* verif/tb_discrete_command_line_controller_core.sv */
// ----------------------------------------------------------------------------
// tb_discrete_command_line_controller_core
// Self-checking bench for the command line controller. A directed table loads
// a small set of ports and commands, then walks STEP, SET (mask and OR forms),
// spare kinds, strobe set/clear and strobe order errors in both strobe modes.
// Random phases follow under several strobe register settings. Each accepted
// request runs through an in-bench model of the tables and strobe state; each
// accepted result is compared field by field with the oldest predicted write.
// ----------------------------------------------------------------------------
module tb_discrete_command_line_controller_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dclc_pkg::*;

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int CMD_COUNT    = 256;
    localparam int PORT_COUNT   = 32;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 30;

    // One directed step: a register write or a request, optionally with
    // hand-written results (n_typed < 0 means use the model)
    typedef struct {
        bit                     is_cfg;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [7:0]             reg_value;
        cmd_req_t               req;
        int                     n_typed;
        rsp_t                   typed0;
        rsp_t                   typed1;
    } step_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cmd_valid;
    logic                   cmd_stall;
    cmd_req_t               cmd_req;
    logic                   rsp_valid;
    logic                   rsp_stall;
    rsp_t                   rsp;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    // Model state: tables, strobe tracking, strobe registers
    logic [1:0]  kind_tbl   [CMD_COUNT];
    logic [4:0]  port_tbl   [CMD_COUNT];
    logic [15:0] mask_tbl   [CMD_COUNT];
    logic [15:0] addr_tbl   [PORT_COUNT];
    logic [15:0] shadow_tbl [PORT_COUNT];
    bit          strobe_on;
    logic [7:0]  strobe_holder;
    bit          strobe_seen;
    bit          strobe_by_sysctl;
    logic [7:0]  strobe_line_cmd;

    rsp_t        item_writes[$];
    rsp_t        line_writes_due[$];

    // Entries loaded so far; only these are ever executed or referenced
    logic [7:0]  cmds_loaded[$];
    bit          cmd_is_loaded [CMD_COUNT];
    logic [4:0]  ports_loaded[$];
    bit          port_is_loaded [PORT_COUNT];

    step_row_t   plan[$];
    bit          no_idling;
    int          mismatches;
    int          stray_results;
    int          reports;
    int          idle_cycles;
    int          n_exec;
    int          n_load;
    int          n_cfg;
    int          n_checked;
    int          n_order_err;

    discrete_command_line_controller_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_req   (cmd_req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // Model of the controller
    // ------------------------------------------------------------------------
    function automatic void add_write(input bit wv, input logic [15:0] waddr,
                                      input logic [15:0] wdata, input bit oerr);
        rsp_t w;
        w = '0;
        w.write_valid        = wv;
        w.write_address      = wv ? waddr : 16'h0000;
        w.write_data         = wv ? wdata : 16'h0000;
        w.strobe_order_error = oerr;
        item_writes.push_back(w);
    endfunction

    // Set or clear a command's mask bits in its port shadow, then write it out
    function automatic void drive_port_line(input logic [7:0] cmd, input bit set_line,
                                            input bit oerr);
        logic [4:0]  p;
        logic [15:0] m;
        p = port_tbl[cmd];
        m = mask_tbl[cmd];
        shadow_tbl[p] = set_line ? (shadow_tbl[p] | m) : (shadow_tbl[p] & ~m);
        add_write(1'b1, addr_tbl[p], shadow_tbl[p], oerr);
    endfunction

    function automatic void predict_line_writes(input cmd_req_t req);
        logic [7:0] cmd;
        logic [4:0] p;
        bit         oerr;
        bit         spare;
        item_writes.delete();
        case (req.mode)
            MODE_LOAD_CMD:
            begin
                kind_tbl[req.entry_index] = req.load_kind;
                port_tbl[req.entry_index] = req.load_port_index;
                mask_tbl[req.entry_index] = req.load_mask;
            end
            MODE_LOAD_PORT:
            begin
                p = 5'(req.entry_index % PORT_COUNT);
                addr_tbl[p]   = req.load_bus_address;
                shadow_tbl[p] = 16'h0000;
            end
            MODE_EXEC:
            begin
                cmd   = req.entry_index;
                spare = (kind_tbl[cmd] == KIND_SPARE);
                case (kind_tbl[cmd])
                    KIND_STRB:
                    begin
                        strobe_seen = 1'b1;
                        if (strobe_on)
                            drive_port_line(strobe_holder, 1'b0, 1'b0);
                        else
                            drive_port_line(cmd, 1'b1, 1'b0);
                    end
                    KIND_STEP:
                    begin
                        drive_port_line(cmd, 1'b1, 1'b0);
                        drive_port_line(cmd, 1'b0, 1'b0);
                    end
                    KIND_SET:
                    begin
                        if (mask_tbl[cmd] != 16'h0000)
                            drive_port_line(cmd, req.set_value != 16'h0000, 1'b0);
                        else
                        begin
                            // zero mask: OR the value straight into the shadow
                            p = port_tbl[cmd];
                            shadow_tbl[p] = shadow_tbl[p] | req.set_value;
                            add_write(1'b1, addr_tbl[p], shadow_tbl[p], 1'b0);
                        end
                    end
                    default:
                        add_write(1'b0, 16'h0000, 16'h0000, 1'b0);
                endcase
                // group end toggles the strobe when the group held a STRB
                if (req.group_end)
                begin
                    if (strobe_seen)
                    begin
                        if (strobe_on)
                        begin
                            oerr = (cmd != strobe_holder);
                            if (strobe_by_sysctl)
                                add_write(1'b1, SYSCTL_ADDR, SYSCTL_CLR, oerr);
                            else
                                drive_port_line(strobe_line_cmd, 1'b0, oerr);
                            strobe_on = 1'b0;
                        end
                        else
                        begin
                            if (strobe_by_sysctl)
                                add_write(1'b1, SYSCTL_ADDR, SYSCTL_SET, 1'b0);
                            else
                                drive_port_line(strobe_line_cmd, 1'b1, 1'b0);
                            strobe_on     = 1'b1;
                            strobe_holder = cmd;
                        end
                    end
                    strobe_seen = 1'b0;
                end
                foreach (item_writes[k])
                begin
                    item_writes[k].reply_status = spare;
                    item_writes[k].last_result  = (k == item_writes.size() - 1);
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic push_request(input step_row_t row);
        int gap;
        gap = no_idling ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_req   <= row.req;
        @(posedge clk);
        while (cmd_stall !== 1'b0)
            @(posedge clk);
        predict_line_writes(row.req);
        if (row.n_typed >= 0)
        begin
            item_writes.delete();
            if (row.n_typed > 0)
                item_writes.push_back(row.typed0);
            if (row.n_typed > 1)
                item_writes.push_back(row.typed1);
        end
        foreach (item_writes[k])
        begin
            line_writes_due.push_back(item_writes[k]);
            if (item_writes[k].strobe_order_error)
                n_order_err++;
        end
        // track what may be referenced from now on
        if (row.req.mode == MODE_EXEC)
            n_exec++;
        if (row.req.mode == MODE_LOAD_CMD)
        begin
            n_load++;
            if (!cmd_is_loaded[row.req.entry_index])
                cmds_loaded.push_back(row.req.entry_index);
            cmd_is_loaded[row.req.entry_index] = 1'b1;
        end
        if (row.req.mode == MODE_LOAD_PORT)
        begin
            n_load++;
            if (!port_is_loaded[row.req.entry_index % PORT_COUNT])
                ports_loaded.push_back(5'(row.req.entry_index % PORT_COUNT));
            port_is_loaded[row.req.entry_index % PORT_COUNT] = 1'b1;
        end
        @(negedge clk);
    endtask

    // Drop valid, let every predicted write drain, then give the block time
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (line_writes_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_strobe_reg(input logic [CFG_INDEX_W-1:0] index,
                                    input logic [7:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        if (index == REG_STROBE_VIA_SYSCTL)
            strobe_by_sysctl = value[0];
        else if (index == REG_STROBE_LINE_CMD)
            strobe_line_cmd = value;
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Row builders
    // ------------------------------------------------------------------------
    function automatic step_row_t exec_row(input logic [7:0] idx, input logic [15:0] val,
                                           input bit gend);
        step_row_t r;
        r.is_cfg          = 1'b0;
        r.reg_index       = '0;
        r.reg_value       = '0;
        r.req             = '0;
        r.req.mode        = MODE_EXEC;
        r.req.entry_index = idx;
        r.req.set_value   = val;
        r.req.group_end   = gend;
        r.n_typed         = -1;
        r.typed0          = '0;
        r.typed1          = '0;
        return r;
    endfunction

    function automatic step_row_t cmd_load_row(input logic [7:0] idx, input logic [1:0] kind,
                                               input logic [4:0] port, input logic [15:0] mask);
        step_row_t r;
        r = exec_row(idx, 16'h0000, 1'b0);
        r.req.mode            = MODE_LOAD_CMD;
        r.req.load_kind       = kind;
        r.req.load_port_index = port;
        r.req.load_mask       = mask;
        r.n_typed             = 0;
        return r;
    endfunction

    function automatic step_row_t port_load_row(input logic [7:0] idx,
                                                input logic [15:0] bus_addr);
        step_row_t r;
        r = exec_row(idx, 16'h0000, 1'b0);
        r.req.mode             = MODE_LOAD_PORT;
        r.req.load_bus_address = bus_addr;
        r.n_typed              = 0;
        return r;
    endfunction

    function automatic step_row_t cfg_row(input logic [CFG_INDEX_W-1:0] index,
                                          input logic [7:0] value);
        step_row_t r;
        r = exec_row(8'd0, 16'h0000, 1'b0);
        r.is_cfg    = 1'b1;
        r.reg_index = index;
        r.reg_value = value;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random requests: mostly well-formed command groups, some loads, some
    // groups cut short and some ignored-mode noise
    // ------------------------------------------------------------------------
    function automatic cmd_req_t random_fields();
        logic [95:0] bits;
        bits = {$urandom(), $urandom(), $urandom()};
        return bits[$bits(cmd_req_t)-1:0];
    endfunction

    task automatic run_random_phase(input int target);
        int        made;
        int        pick;
        int        len;
        step_row_t r;
        made = 0;
        while (made < target)
        begin
            pick = $urandom_range(0, 99);
            r = exec_row(8'd0, 16'h0000, 1'b0);
            r.req = random_fields();
            if (pick < 60)
            begin
                len = $urandom_range(1, 3);
                for (int j = 0; j < len; j++)
                begin
                    r.req = random_fields();
                    r.req.mode        = MODE_EXEC;
                    r.req.entry_index = cmds_loaded[$urandom_range(0, cmds_loaded.size() - 1)];
                    r.req.group_end   = (j == len - 1);
                    if ($urandom_range(0, 3) == 0)
                        r.req.set_value = 16'h0000;
                    push_request(r);
                end
                made += len;
            end
            else if (pick < 75)
            begin
                r.req.mode            = MODE_LOAD_CMD;
                r.req.entry_index     = 8'($urandom_range(0, 254));
                r.req.load_port_index =
                    ports_loaded[$urandom_range(0, ports_loaded.size() - 1)];
                case ($urandom_range(0, 9))
                    0: r.req.load_mask = 16'h0000;
                    1: r.req.load_mask = 16'hFFFF;
                    default: ;
                endcase
                push_request(r);
                made++;
            end
            else if (pick < 85)
            begin
                r.req.mode        = MODE_LOAD_PORT;
                r.req.entry_index = 8'($urandom_range(0, 254));
                push_request(r);
                made++;
            end
            else if (pick < 93)
            begin
                // lone execute, group end left to chance
                r.req.mode        = MODE_EXEC;
                r.req.entry_index = cmds_loaded[$urandom_range(0, cmds_loaded.size() - 1)];
                push_request(r);
                made++;
            end
            else
            begin
                r.req.mode = MODE_IGNORED;
                push_request(r);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall, then compare with the oldest prediction
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            reports++;
            if (reports <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected 0x%04h, got 0x%04h",
                         $realtime, name, want, got);
        end
    endtask

    task automatic check_result(input rsp_t got);
        rsp_t want;
        n_checked++;
        if (line_writes_due.size() == 0)
        begin
            stray_results++;
            reports++;
            if (reports <= MAX_REPORTS)
                $display("%0t: result with nothing pending: %p", $realtime, got);
        end
        else
        begin
            want = line_writes_due.pop_front();
            compare_field("write_valid", 16'(want.write_valid), 16'(got.write_valid));
            compare_field("write_address", want.write_address, got.write_address);
            compare_field("write_data", want.write_data, got.write_data);
            compare_field("reply_status", 16'(want.reply_status), 16'(got.reply_status));
            compare_field("strobe_order_error", 16'(want.strobe_order_error),
                          16'(got.strobe_order_error));
            compare_field("last_result", 16'(want.last_result), 16'(got.last_result));
        end
    endtask

    initial
    begin
        int hold;
        rsp_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            hold = no_idling ? 0 : $urandom_range(0, 3);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            @(posedge clk);
            while (rsp_valid !== 1'b1)
                @(posedge clk);
            check_result(rsp);
        end
    end

    // Watchdog: any handshake on any channel counts as progress
    always @(posedge clk)
    begin
        if ((cmd_valid === 1'b1 && cmd_stall === 1'b0) ||
            (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
            (cfg_valid === 1'b1 && cfg_ready === 1'b1) || rst_n !== 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     IDLE_LIMIT, line_writes_due.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        step_row_t  r;
        logic [7:0] line_pick;
        rst_n            = 1'b0;
        cmd_valid        = 1'b0;
        cmd_req          = '0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        no_idling        = 1'b0;
        strobe_on        = 1'b0;
        strobe_holder    = 8'd0;
        strobe_seen      = 1'b0;
        strobe_by_sysctl = 1'b0;
        strobe_line_cmd  = 8'd0;
        idle_cycles      = 0;
        foreach (shadow_tbl[i])
            shadow_tbl[i] = 16'h0000;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: line strobe on command 0 first
        plan.push_back(cfg_row(REG_STROBE_VIA_SYSCTL, 8'd0));
        plan.push_back(cfg_row(REG_STROBE_LINE_CMD, 8'd0));
        plan.push_back(port_load_row(8'd0, 16'hFFFF));
        plan.push_back(port_load_row(8'd63, 16'h0000));     // wraps to port 31
        plan.push_back(port_load_row(8'd254, 16'h1234));    // wraps to port 30
        plan.push_back(cmd_load_row(8'd0, KIND_STRB, 5'd0, 16'h0001));
        plan.push_back(cmd_load_row(8'd254, KIND_STEP, 5'd31, 16'hFFFF));
        plan.push_back(cmd_load_row(8'd1, KIND_SET, 5'd30, 16'h00F0));
        plan.push_back(cmd_load_row(8'd2, KIND_SET, 5'd30, 16'h0000));
        plan.push_back(cmd_load_row(8'd3, KIND_SPARE, 5'd0, 16'h0002));
        plan.push_back(cmd_load_row(8'd4, KIND_STRB, 5'd31, 16'h8000));
        // ignored mode with every bit high: no result
        r = exec_row(8'd0, 16'h0000, 1'b0);
        r.req = '1;
        r.n_typed = 0;
        plan.push_back(r);
        plan.push_back(exec_row(8'd254, 16'h0000, 1'b0));
        plan.push_back(exec_row(8'd1, 16'hFFFF, 1'b0));
        plan.push_back(exec_row(8'd1, 16'h0000, 1'b0));
        plan.push_back(exec_row(8'd2, 16'hA5A5, 1'b0));
        plan.push_back(exec_row(8'd2, 16'h0000, 1'b0));
        // spare kind: one empty result flagged unknown
        r = exec_row(8'd3, 16'h0000, 1'b0);
        r.n_typed = 1;
        r.typed0  = '{1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1};
        plan.push_back(r);
        // strobe set, clear by the owner, then clear by another command
        plan.push_back(exec_row(8'd4, 16'h0000, 1'b1));
        plan.push_back(exec_row(8'd4, 16'h0000, 1'b1));
        plan.push_back(exec_row(8'd4, 16'h0000, 1'b0));
        plan.push_back(exec_row(8'd254, 16'h0000, 1'b1));
        plan.push_back(exec_row(8'd4, 16'h0000, 1'b1));
        // system controller strobe
        plan.push_back(cfg_row(REG_STROBE_VIA_SYSCTL, 8'd1));
        plan.push_back(cfg_row(REG_STROBE_LINE_CMD, 8'd254));
        plan.push_back(exec_row(8'd4, 16'h0000, 1'b0));
        r = exec_row(8'd3, 16'h0000, 1'b1);
        r.n_typed = 2;
        r.typed0  = '{1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0};
        r.typed1  = '{1'b1, SYSCTL_ADDR, SYSCTL_SET, 1'b1, 1'b0, 1'b1};
        plan.push_back(r);
        plan.push_back(exec_row(8'd4, 16'h0000, 1'b1));
        plan.push_back(exec_row(8'd2, 16'h0001, 1'b1));

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_strobe_reg(plan[i].reg_index, plan[i].reg_value);
            else
                push_request(plan[i]);
        end

        // Random phases under different strobe settings; phase 2 runs flat out
        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph == 2)
                line_pick = 8'd254;
            else if (ph == 3)
                line_pick = 8'd0;
            else
                line_pick = cmds_loaded[$urandom_range(0, cmds_loaded.size() - 1)];
            write_strobe_reg(REG_STROBE_VIA_SYSCTL, {7'd0, ph[0]});
            write_strobe_reg(REG_STROBE_LINE_CMD, line_pick);
            no_idling = (ph == 2);
            run_random_phase(PHASE_ITEMS);
        end

        wait_idle();
        $display("covered %0d executes and %0d table loads, %0d results checked",
                 n_exec, n_load, n_checked);
        $display("%0d register writes, %0d strobe order errors, %0d failures",
                 n_cfg, n_order_err, mismatches + stray_results);
        if (mismatches == 0 && stray_results == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/dclc_pkg.sv
sv/dclc_ram.sv
sv/discrete_command_line_controller_core.sv
sv/dclc_checker.sv
verif/tb_discrete_command_line_controller_core.sv
